// File: hdl/gcsp_pkg.sv
// Shared types, codes and constants of the glyph cache shelf packer.
`timescale 1ns / 1ps
package gcsp_pkg;

  localparam int DIM_W    = 13;
  localparam int NEXT_W   = DIM_W + 1;
  localparam int KEY_W    = 21;
  localparam int MET_W    = 16;
  localparam int CALC_W   = 16;
  localparam int REG_IDX_W = 1;

  localparam int HASH_SLOTS_DEF  = 4096;
  localparam int MAX_SHELVES_DEF = 128;
  localparam int GAP_PIXELS_DEF  = 1;
  localparam int MAX_DIM_DEF     = 4096;

  localparam logic [DIM_W-1:0] ATLAS_DIM_RST = 13'd1024;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ATLAS_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'd1;

  typedef struct packed {
    logic                    kind;
    logic [KEY_W-1:0]        codepoint;
    logic [DIM_W-1:0]        glyph_width;
    logic [DIM_W-1:0]        glyph_height;
    logic signed [MET_W-1:0] bearing_x_in;
    logic signed [MET_W-1:0] bearing_y_in;
    logic signed [MET_W-1:0] advance_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [DIM_W-1:0]        out_pos_x;
    logic [DIM_W-1:0]        out_pos_y;
    logic [DIM_W-1:0]        out_width;
    logic [DIM_W-1:0]        out_height;
    logic signed [MET_W-1:0] out_bearing_x;
    logic signed [MET_W-1:0] out_bearing_y;
    logic signed [MET_W-1:0] out_advance;
  } result_t;

  typedef struct packed {
    logic                    valid;
    logic [KEY_W-1:0]        key;
    logic [DIM_W-1:0]        pos_x;
    logic [DIM_W-1:0]        pos_y;
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic signed [MET_W-1:0] met_x;
    logic signed [MET_W-1:0] met_y;
    logic signed [MET_W-1:0] advance;
  } slot_entry_t;

  // next_x is one bit wider: a new shelf's next_x may lie past the atlas width
  typedef struct packed {
    logic [NEXT_W-1:0] next_x;
    logic [DIM_W-1:0]  top;
    logic [DIM_W-1:0]  tallest;
  } shelf_entry_t;

endpackage

// File: hdl/gcsp_slot_ram.sv
// Hash slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module gcsp_slot_ram import gcsp_pkg::*; #(
  parameter int HASH_SLOTS = HASH_SLOTS_DEF,
  localparam int AW = $clog2(HASH_SLOTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output slot_entry_t   rdata
);

  slot_entry_t mem [HASH_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gcsp_shelf_ram.sv
// Shelf table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module gcsp_shelf_ram import gcsp_pkg::*; #(
  parameter int MAX_SHELVES = MAX_SHELVES_DEF,
  localparam int SIW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [SIW-1:0] waddr,
  input  shelf_entry_t   wdata,
  input  logic [SIW-1:0] raddr,
  output shelf_entry_t   rdata
);

  shelf_entry_t mem [MAX_SHELVES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/glyph_cache_shelf_packer.sv
// Top level of the glyph cache: probe sequencer, shelf packer and result register.
//
//  port group      dir   handshake           word
//  command         in    start & !busy       cmd (cmd_t)
//  result          out   done, one cycle     result (result_t)
//  configuration   in    cfg_we              cfg_index, cfg_data
//
// A lookup walks the probe sequence from the home slot, one slot read per cycle from the
// slot memory, and done is registered after the last slot read. An insert first scans the
// shelves newest first (one shelf read per cycle) and opens a new shelf if none fits, then
// probes; an insert refused at the load limit answers in the next cycle. After reset a
// clearing pass over all HASH_SLOTS slots holds busy high; configuration writes are taken.
// The result cannot be stalled; a new command may start in the cycle of done.
`timescale 1ns / 1ps
module glyph_cache_shelf_packer import gcsp_pkg::*; #(
  parameter int HASH_SLOTS  = HASH_SLOTS_DEF,
  parameter int MAX_SHELVES = MAX_SHELVES_DEF,
  parameter int GAP_PIXELS  = GAP_PIXELS_DEF,
  parameter int MAX_DIM     = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW     = $clog2(HASH_SLOTS);
  localparam int SIW    = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int SCW    = $clog2(MAX_SHELVES + 1);
  localparam int THRESH = HASH_SLOTS * 3 / 4;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_NEW   = 3'd4;

  localparam logic [CALC_W-1:0] GAP  = CALC_W'(GAP_PIXELS);
  localparam logic [CALC_W-1:0] DCAP = CALC_W'(MAX_DIM);

  logic [2:0]       state, state_next;
  cmd_t             cmd_r, cmd_r_next;
  logic [AW-1:0]    probe_idx, probe_idx_next;
  logic [AW-1:0]    probe_cnt, probe_cnt_next;
  logic [SIW-1:0]   shelf_idx, shelf_idx_next;
  logic [SCW-1:0]   shelf_total, shelf_total_next;
  logic [AW-1:0]    entry_total, entry_total_next;
  logic [DIM_W-1:0] last_top, last_top_next, last_tall, last_tall_next;
  logic [DIM_W-1:0] gx, gx_next, gy, gy_next;
  logic [DIM_W-1:0] atlas_width, atlas_height;
  logic             done_next;
  result_t          result_next;

  logic             slot_we, shelf_we;
  slot_entry_t      slot_wdata, slot_rd;
  shelf_entry_t     shelf_wdata, shelf_rd;
  logic [AW-1:0]    slot_waddr;
  logic [SIW-1:0]   shelf_waddr;

  logic             accept;
  logic [CALC_W-1:0] aw, ah, bw, bh, fit_x, fit_y, ny, ny_end;
  logic [SIW-1:0]   last_idx;
  logic             fit;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign last_idx = SIW'(shelf_total - SCW'(1));

  always_comb begin
    aw = (CALC_W'(atlas_width) > DCAP) ? DCAP : CALC_W'(atlas_width);
    ah = (CALC_W'(atlas_height) > DCAP) ? DCAP : CALC_W'(atlas_height);
    bw = CALC_W'(cmd_r.glyph_width);
    bh = CALC_W'(cmd_r.glyph_height);
    fit_x = CALC_W'(shelf_rd.next_x) + bw + GAP;
    fit_y = CALC_W'(shelf_rd.top) + bh + GAP;
    fit   = (fit_x <= aw) && (fit_y <= ah);
    ny    = (shelf_total == '0) ? '0 :
            CALC_W'(last_top) + CALC_W'(last_tall) + GAP;
    ny_end = ny + bh + GAP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= ATLAS_DIM_RST;
      atlas_height <= ATLAS_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        REG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next       = state;
    cmd_r_next       = cmd_r;
    probe_idx_next   = probe_idx;
    probe_cnt_next   = probe_cnt;
    shelf_idx_next   = shelf_idx;
    shelf_total_next = shelf_total;
    entry_total_next = entry_total;
    last_top_next    = last_top;
    last_tall_next   = last_tall;
    gx_next          = gx;
    gy_next          = gy;
    done_next        = 1'b0;
    result_next      = '0;
    slot_we          = 1'b0;
    slot_waddr       = probe_idx;
    slot_wdata       = '0;
    shelf_we         = 1'b0;
    shelf_waddr      = shelf_idx;
    shelf_wdata      = '0;

    case (state)
      S_CLEAR: begin
        slot_we        = 1'b1;
        probe_idx_next = probe_idx + AW'(1);
        if (probe_idx == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_r_next     = cmd;
          probe_idx_next = cmd.codepoint[AW-1:0];
          probe_cnt_next = '0;
          gx_next        = '0;
          gy_next        = '0;
          shelf_idx_next = last_idx;
          if (cmd.kind == KIND_LOOKUP) begin
            state_next = S_PROBE;
          end else if (entry_total >= AW'(THRESH)) begin
            done_next          = 1'b1;
            result_next.status = ST_NO_ROOM;
          end else if (cmd.glyph_width == '0 || cmd.glyph_height == '0) begin
            state_next = S_PROBE;
          end else if (shelf_total == '0) begin
            state_next = S_NEW;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // shelf_rd holds the shelf at shelf_idx, newest first
        if (shelf_idx == last_idx) begin
          last_top_next  = shelf_rd.top;
          last_tall_next = shelf_rd.tallest;
        end
        if (fit) begin
          shelf_we            = 1'b1;
          shelf_wdata.next_x  = NEXT_W'(fit_x);
          shelf_wdata.top     = shelf_rd.top;
          shelf_wdata.tallest = (bh > CALC_W'(shelf_rd.tallest)) ?
                                cmd_r.glyph_height : shelf_rd.tallest;
          gx_next    = DIM_W'(shelf_rd.next_x);
          gy_next    = shelf_rd.top;
          state_next = S_PROBE;
        end else if (shelf_idx == '0) begin
          state_next = S_NEW;
        end else begin
          shelf_idx_next = shelf_idx - SIW'(1);
        end
      end
      S_NEW: begin
        if (shelf_total >= SCW'(MAX_SHELVES) || ny_end > ah) begin
          done_next          = 1'b1;
          result_next.status = ST_NO_ROOM;
          state_next         = S_IDLE;
        end else begin
          shelf_we            = 1'b1;
          shelf_waddr         = SIW'(shelf_total);
          shelf_wdata.next_x  = NEXT_W'(bw + GAP);
          shelf_wdata.top     = DIM_W'(ny);
          shelf_wdata.tallest = cmd_r.glyph_height;
          shelf_total_next    = shelf_total + SCW'(1);
          gx_next    = '0;
          gy_next    = DIM_W'(ny);
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        // slot_rd holds the slot at probe_idx
        if (!slot_rd.valid) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (cmd_r.kind == KIND_LOOKUP) begin
            result_next.status = ST_MISS;
          end else begin
            slot_we              = 1'b1;
            slot_wdata.valid     = 1'b1;
            slot_wdata.key       = cmd_r.codepoint;
            slot_wdata.pos_x     = gx;
            slot_wdata.pos_y     = gy;
            slot_wdata.width     = cmd_r.glyph_width;
            slot_wdata.height    = cmd_r.glyph_height;
            slot_wdata.met_x     = cmd_r.bearing_x_in;
            slot_wdata.met_y     = cmd_r.bearing_y_in;
            slot_wdata.advance   = cmd_r.advance_in;
            entry_total_next     = entry_total + AW'(1);
            result_next.status        = ST_OK;
            result_next.out_pos_x     = gx;
            result_next.out_pos_y     = gy;
            result_next.out_width     = cmd_r.glyph_width;
            result_next.out_height    = cmd_r.glyph_height;
            result_next.out_bearing_x = cmd_r.bearing_x_in;
            result_next.out_bearing_y = cmd_r.bearing_y_in;
            result_next.out_advance   = cmd_r.advance_in;
          end
        end else if (cmd_r.kind == KIND_LOOKUP && slot_rd.key == cmd_r.codepoint) begin
          done_next                 = 1'b1;
          state_next                = S_IDLE;
          result_next.status        = ST_OK;
          result_next.out_pos_x     = slot_rd.pos_x;
          result_next.out_pos_y     = slot_rd.pos_y;
          result_next.out_width     = slot_rd.width;
          result_next.out_height    = slot_rd.height;
          result_next.out_bearing_x = slot_rd.met_x;
          result_next.out_bearing_y = slot_rd.met_y;
          result_next.out_advance   = slot_rd.advance;
        end else if (probe_cnt == '1) begin
          // whole table walked
          done_next          = 1'b1;
          state_next         = S_IDLE;
          result_next.status = (cmd_r.kind == KIND_LOOKUP) ? ST_MISS : ST_NO_ROOM;
        end else begin
          probe_idx_next = probe_idx + AW'(1);
          probe_cnt_next = probe_cnt + AW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      probe_idx   <= '0;
      probe_cnt   <= '0;
      shelf_idx   <= '0;
      shelf_total <= '0;
      entry_total <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      probe_idx   <= probe_idx_next;
      probe_cnt   <= probe_cnt_next;
      shelf_idx   <= shelf_idx_next;
      shelf_total <= shelf_total_next;
      entry_total <= entry_total_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_r_next;
    last_top  <= last_top_next;
    last_tall <= last_tall_next;
    gx        <= gx_next;
    gy        <= gy_next;
    result    <= result_next;
  end

  gcsp_slot_ram #(.HASH_SLOTS(HASH_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (probe_idx_next),
    .rdata (slot_rd)
  );

  gcsp_shelf_ram #(.MAX_SHELVES(MAX_SHELVES)) u_shelf_ram (
    .clk   (clk),
    .we    (shelf_we),
    .waddr (shelf_waddr),
    .wdata (shelf_wdata),
    .raddr (shelf_idx_next),
    .rdata (shelf_rd)
  );

  // a refused insert answers straight from idle
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || accept))
    else $error("result word without a command in flight");

  a_entry_limit: assert property (@(posedge clk) disable iff (rst)
    entry_total <= AW'(THRESH))
    else $error("entry count beyond load limit");

  a_shelf_limit: assert property (@(posedge clk) disable iff (rst)
    shelf_total <= SCW'(MAX_SHELVES))
    else $error("shelf count beyond limit");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !done)
    else $error("result word during clearing pass");

endmodule

// File: bench/testbench.sv
// Testbench for the glyph cache shelf packer: directed and random words against a predictor.
`timescale 1ns / 1ps
module testbench;
  import gcsp_pkg::*;

  localparam int SLOTS   = 4096;
  localparam int SHELVES = 128;
  localparam int GAP     = 1;
  localparam int DIM_MAX = 4096;
  localparam longint CYCLE_LIMIT = 40000000;

  class glyph_scoreboard;
    bit              valid_q[SLOTS];
    bit [KEY_W-1:0]  key_q[SLOTS];
    result_t         rec_q[SLOTS];
    int unsigned     sh_next[SHELVES];
    int unsigned     sh_top[SHELVES];
    int unsigned     sh_tall[SHELVES];
    int unsigned     shelf_cnt;
    int unsigned     entry_cnt;
    int unsigned     atlas_w;
    int unsigned     atlas_h;
    result_t         pending[$];
    int              errors;
    int              checked;
    int              hits;
    int              misses;
    int              refusals;

    function new();
      atlas_w = 1024;
      atlas_h = 1024;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
      if (idx == REG_ATLAS_WIDTH) atlas_w = v;
      else atlas_h = v;
    endfunction

    function bit shelf_place(int unsigned bw, int unsigned bh,
                             output int unsigned gx, output int unsigned gy);
      int unsigned aw, ah, ny, s;
      aw = (atlas_w > DIM_MAX) ? DIM_MAX : atlas_w;
      ah = (atlas_h > DIM_MAX) ? DIM_MAX : atlas_h;
      for (int i = shelf_cnt; i > 0; i--) begin
        s = i - 1;
        if (sh_next[s] + bw + GAP <= aw && sh_top[s] + bh + GAP <= ah) begin
          gx = sh_next[s];
          gy = sh_top[s];
          sh_next[s] += bw + GAP;
          if (bh > sh_tall[s]) sh_tall[s] = bh;
          return 1;
        end
      end
      if (shelf_cnt >= SHELVES) return 0;
      ny = 0;
      if (shelf_cnt > 0) ny = sh_top[shelf_cnt-1] + sh_tall[shelf_cnt-1] + GAP;
      if (ny + bh + GAP > ah) return 0;
      sh_top[shelf_cnt] = ny;
      sh_tall[shelf_cnt] = bh;
      sh_next[shelf_cnt] = bw + GAP;
      shelf_cnt++;
      gx = 0;
      gy = ny;
      return 1;
    endfunction

    function void note_cmd(cmd_t c);
      result_t r;
      int unsigned home, idx, gx, gy;
      r = '0;
      home = c.codepoint % SLOTS;
      if (c.kind == KIND_LOOKUP) begin
        r.status = ST_MISS;
        for (int i = 0; i < SLOTS; i++) begin
          idx = (home + i) % SLOTS;
          if (!valid_q[idx]) break;
          if (key_q[idx] == c.codepoint) begin
            r = rec_q[idx];
            break;
          end
        end
      end else begin
        gx = 0;
        gy = 0;
        r.status = ST_NO_ROOM;
        if (entry_cnt < SLOTS * 3 / 4 &&
            (c.glyph_width == 0 || c.glyph_height == 0 ||
             shelf_place(c.glyph_width, c.glyph_height, gx, gy))) begin
          for (int i = 0; i < SLOTS; i++) begin
            idx = (home + i) % SLOTS;
            if (!valid_q[idx]) begin
              r.status = ST_OK;
              r.out_pos_x = DIM_W'(gx);
              r.out_pos_y = DIM_W'(gy);
              r.out_width = c.glyph_width;
              r.out_height = c.glyph_height;
              r.out_bearing_x = c.bearing_x_in;
              r.out_bearing_y = c.bearing_y_in;
              r.out_advance = c.advance_in;
              valid_q[idx] = 1;
              key_q[idx] = c.codepoint;
              rec_q[idx] = r;
              entry_cnt++;
              break;
            end
          end
        end
      end
      if (r.status == ST_OK && c.kind == KIND_LOOKUP) hits++;
      if (r.status == ST_MISS) misses++;
      if (r.status == ST_NO_ROOM) refusals++;
      pending.push_back(r);
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, checked);
      errors++;
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", got.status, -1);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report_mismatch("status", got.status, w.status);
      if (got.out_pos_x !== w.out_pos_x) report_mismatch("pos_x", got.out_pos_x, w.out_pos_x);
      if (got.out_pos_y !== w.out_pos_y) report_mismatch("pos_y", got.out_pos_y, w.out_pos_y);
      if (got.out_width !== w.out_width) report_mismatch("width", got.out_width, w.out_width);
      if (got.out_height !== w.out_height)
        report_mismatch("height", got.out_height, w.out_height);
      if (got.out_bearing_x !== w.out_bearing_x)
        report_mismatch("horizontal bearing", got.out_bearing_x, w.out_bearing_x);
      if (got.out_bearing_y !== w.out_bearing_y)
        report_mismatch("vertical bearing", got.out_bearing_y, w.out_bearing_y);
      if (got.out_advance !== w.out_advance)
        report_mismatch("advance", got.out_advance, w.out_advance);
      checked++;
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  cmd_t                 cmd;
  logic                 done;
  result_t              result;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  glyph_scoreboard sb;
  longint          cycles = 0;
  int              idle_pct;
  int              sent;
  bit [KEY_W-1:0]  used_keys[$];

  glyph_cache_shelf_packer u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(result);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // start stays high after an accept until the next word or an idle gap
  task automatic send_cmd(cmd_t c);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    // accepted at this edge
    sb.note_cmd(c);
    sent++;
    if (c.kind == KIND_INSERT) used_keys.push_back(c.codepoint);
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (sb.pending.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(bit k, bit [KEY_W-1:0] cp, int unsigned w, int unsigned h);
    cmd_t c;
    c.kind = k;
    c.codepoint = cp;
    c.glyph_width = DIM_W'(w);
    c.glyph_height = DIM_W'(h);
    c.bearing_x_in = MET_W'($urandom);
    c.bearing_y_in = MET_W'($urandom);
    c.advance_in = MET_W'($urandom);
    return c;
  endfunction

  function automatic bit [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40 && used_keys.size() > 0)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    if (r < 70) return KEY_W'($urandom_range(63) * SLOTS + $urandom_range(15)); // clustered
    if (r < 75) return 21'h10FFFF;
    return KEY_W'($urandom_range(1114111));
  endfunction

  task automatic random_phase(int n, int pct, int maxdim);
    cmd_t c;
    idle_pct = pct;
    repeat (n) begin
      c = make_cmd($urandom_range(99) < 55, pick_key(),
                   $urandom_range(maxdim), $urandom_range(maxdim));
      if ($urandom_range(19) == 0) c.glyph_width = '0;
      if ($urandom_range(49) == 0) c.glyph_height = DIM_W'($urandom_range(8191));
      if ($urandom_range(49) == 0) c.glyph_width = DIM_W'($urandom_range(8191));
      send_cmd(c);
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ATLAS_WIDTH;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicates, empty and oversized glyphs
    send_cmd(make_cmd(KIND_LOOKUP, 21'd0, 0, 0));
    send_cmd(make_cmd(KIND_INSERT, 21'd0, 10, 20));
    send_cmd(make_cmd(KIND_INSERT, 21'd4096, 8191, 8191));
    send_cmd(make_cmd(KIND_INSERT, 21'd4096, 0, 5));
    send_cmd(make_cmd(KIND_INSERT, 21'd4096, 7, 0));
    send_cmd(make_cmd(KIND_INSERT, 21'h10FFFF, 1022, 3));
    send_cmd(make_cmd(KIND_INSERT, 21'h1FFFFF, 1, 1));
    send_cmd(make_cmd(KIND_INSERT, 21'd8192, 4096, 4096));
    send_cmd(make_cmd(KIND_INSERT, 21'd1, 1023, 1022));
    send_cmd(make_cmd(KIND_LOOKUP, 21'd4096, 8191, 8191));
    send_cmd(make_cmd(KIND_LOOKUP, 21'd8192, 0, 0));
    send_cmd(make_cmd(KIND_LOOKUP, 21'h1FFFFF, 0, 0));
    send_cmd(make_cmd(KIND_LOOKUP, 21'd12288, 0, 0));
    begin
      cmd_t c;
      c = make_cmd(KIND_INSERT, 21'd5, 3, 3);
      c.bearing_x_in = 16'sh8000; c.bearing_y_in = 16'sh7FFF; c.advance_in = 16'shFFFF;
      send_cmd(c);
      c = make_cmd(KIND_INSERT, 21'd6, 3, 3);
      c.bearing_x_in = 16'sh7FFF; c.bearing_y_in = 16'sh8000; c.advance_in = 16'sh0000;
      send_cmd(c);
    end
    drain();

    // zero atlas, then oversized registers acting as the cap
    write_reg(REG_ATLAS_WIDTH, 13'd0);
    write_reg(REG_ATLAS_HEIGHT, 13'd0);
    send_cmd(make_cmd(KIND_INSERT, 21'd77, 1, 1));
    send_cmd(make_cmd(KIND_INSERT, 21'd78, 0, 0));
    drain();
    write_reg(REG_ATLAS_WIDTH, 13'h1FFF);
    write_reg(REG_ATLAS_HEIGHT, 13'h1FFF);
    send_cmd(make_cmd(KIND_INSERT, 21'd79, 4095, 4000));
    send_cmd(make_cmd(KIND_INSERT, 21'd80, 4095, 94));
    send_cmd(make_cmd(KIND_INSERT, 21'd81, 100, 2));
    drain();

    // random phases with varied geometry and idling
    write_reg(REG_ATLAS_WIDTH, 13'd4096);
    write_reg(REG_ATLAS_HEIGHT, 13'd4096);
    random_phase(300, 0, 40);
    drain();
    write_reg(REG_ATLAS_WIDTH, 13'd1);
    write_reg(REG_ATLAS_HEIGHT, 13'd2);
    random_phase(100, 70, 3);
    drain();
    write_reg(REG_ATLAS_WIDTH, 13'd300);
    write_reg(REG_ATLAS_HEIGHT, 13'd4096);
    random_phase(400, 22, 12);
    drain();
    write_reg(REG_ATLAS_WIDTH, 13'd2048);
    write_reg(REG_ATLAS_HEIGHT, 13'd1);
    random_phase(100, 0, 4);
    drain();
    write_reg(REG_ATLAS_WIDTH, 13'd4096);
    write_reg(REG_ATLAS_HEIGHT, 13'd4096);
    random_phase(500, 70, 6);
    drain();
    // back to back on the full-size atlas
    random_phase(200, 0, 6);
    drain();

    $display("%0d words sent, %0d results checked: %0d lookup hits, %0d misses, %0d refusals",
             sent, sb.checked, sb.hits, sb.misses, sb.refusals);
    $display("%0d entries stored on %0d shelves", sb.entry_cnt, sb.shelf_cnt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors, %0d results outstanding", sb.errors, sb.pending.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/gcsp_pkg.sv
hdl/gcsp_slot_ram.sv
hdl/gcsp_shelf_ram.sv
hdl/glyph_cache_shelf_packer.sv
bench/testbench.sv
